// ===== src/ffa_pkg.sv =====
// shared types, constants and codes for the first-fit heap allocator
// no dependencies; imported by every module of the block
`default_nettype none

package ffa_pkg;

	localparam int ARENA_BYTES = 4096;
	localparam int GRANULE     = 16;
	localparam int NGRAN       = ARENA_BYTES / GRANULE;
	localparam int GRAN_W      = $clog2(GRANULE);
	localparam int IDX_W       = $clog2(NGRAN);
	localparam int SZ_W        = IDX_W;
	localparam int REQ_W       = 13;
	localparam int HDL_W       = 12;
	localparam int OFS_W       = IDX_W + GRAN_W;
	localparam int NEED_W      = REQ_W - GRAN_W + 1;
	localparam int ALU_W       = (NEED_W > IDX_W + 1) ? NEED_W : IDX_W + 1;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_NOFIT = 2'd1;
	localparam logic [1:0] STAT_BADH  = 2'd2;

	typedef enum logic [1:0] {
		ALU_ADD,
		ALU_ADD_INC,
		ALU_SUB,
		ALU_SUB_DEC
	} alu_op_t;

	typedef struct packed {
		logic            free;
		logic [SZ_W-1:0] size;
	} entry_t;

	localparam entry_t ENTRY_RESET = '{free: 1'b1, size: SZ_W'(NGRAN - 1)};

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		entry_t           wdata;
		logic [IDX_W-1:0] raddr;
	} ram_req_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [OFS_W-1:0] offset;
		logic [OFS_W-1:0] free_bytes;
		logic [OFS_W-1:0] largest_free;
	} result_t;

endpackage

`default_nettype wire

// ===== src/ffa_table.sv =====
// block header table: one entry per granule, one write and one registered read per cycle
// depends on ffa_pkg; header 0 reads as the reset block until first written
`default_nettype none

module ffa_table (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire ffa_pkg::ram_req_t req,
	output ffa_pkg::entry_t        rd_data
);
	import ffa_pkg::*;

	entry_t mem [NGRAN];
	entry_t rd_q;
	logic   fresh0_q;
	logic   rd_fresh_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		rd_q <= mem[req.raddr];
	end

	// entry 0 holds the whole arena after reset without a clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fresh0_q   <= 1'b1;
			rd_fresh_q <= 1'b0;
		end else begin
			if (req.we && req.waddr == '0) begin
				fresh0_q <= 1'b0;
			end
			rd_fresh_q <= fresh0_q && (req.raddr == '0);
		end
	end

	assign rd_data = rd_fresh_q ? ENTRY_RESET : rd_q;

endmodule

`default_nettype wire

// ===== src/ffa_alu.sv =====
// shared adder/subtractor used by the arithmetic steps of the sequencer
// depends on ffa_pkg; top bit of the result is the carry (no borrow on subtract)
`default_nettype none

module ffa_alu (
	input  wire ffa_pkg::alu_op_t          op,
	input  wire logic [ffa_pkg::ALU_W-1:0] a,
	input  wire logic [ffa_pkg::ALU_W-1:0] b,
	output logic [ffa_pkg::ALU_W:0]        res
);
	import ffa_pkg::*;

	logic             inv;
	logic             cin;
	logic [ALU_W-1:0] b_eff;

	always_comb begin
		unique case (op)
			ALU_ADD:     begin inv = 1'b0; cin = 1'b0; end
			ALU_ADD_INC: begin inv = 1'b0; cin = 1'b1; end
			ALU_SUB:     begin inv = 1'b1; cin = 1'b1; end
			ALU_SUB_DEC: begin inv = 1'b1; cin = 1'b0; end
			default:     begin inv = 1'b0; cin = 1'b0; end
		endcase
	end

	assign b_eff = inv ? ~b : b;
	assign res   = {1'b0, a} + {1'b0, b_eff} + (ALU_W + 1)'(cin);

endmodule

`default_nettype wire

// ===== src/ffa_ctrl.sv =====
// sequencer: walks block headers for search, free, merge and totals passes
// depends on ffa_pkg, ffa_table, ffa_alu
`default_nettype none

module ffa_ctrl (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic                      req_type,
	input  wire logic [ffa_pkg::REQ_W-1:0] req_size,
	input  wire logic [ffa_pkg::HDL_W-1:0] handle,
	input  wire logic                      take,
	output logic                           idle,
	output logic                           done,
	output ffa_pkg::result_t               result
);
	import ffa_pkg::*;

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] A_RD   = 5'd1;
	localparam logic [4:0] A_CMP  = 5'd2;
	localparam logic [4:0] A_NXT  = 5'd3;
	localparam logic [4:0] A_REM  = 5'd4;
	localparam logic [4:0] A_RADR = 5'd5;
	localparam logic [4:0] A_WR   = 5'd6;
	localparam logic [4:0] D_RD   = 5'd7;
	localparam logic [4:0] D_EV   = 5'd8;
	localparam logic [4:0] C_RD   = 5'd9;
	localparam logic [4:0] C_EV   = 5'd10;
	localparam logic [4:0] C_NRD  = 5'd11;
	localparam logic [4:0] C_NEV  = 5'd12;
	localparam logic [4:0] C_NXT  = 5'd13;
	localparam logic [4:0] T_RD   = 5'd14;
	localparam logic [4:0] T_EV   = 5'd15;
	localparam logic [4:0] T_MAX  = 5'd16;
	localparam logic [4:0] T_NXT  = 5'd17;
	localparam logic [4:0] S_DONE = 5'd18;

	logic [4:0]        state_q;
	logic [IDX_W:0]    g_q;
	logic [IDX_W:0]    nb_q;
	logic [SZ_W-1:0]   sz_q;
	logic              fr_q;
	logic [SZ_W-1:0]   diff_q;
	logic [SZ_W-1:0]   rem_q;
	logic              split_q;
	logic [NEED_W-1:0] need_q;
	logic [IDX_W-1:0]  target_q;
	logic [SZ_W-1:0]   tot_q;
	logic [SZ_W-1:0]   best_q;
	logic [1:0]        status_q;
	logic [OFS_W-1:0]  offset_q;

	ram_req_t          ram;
	entry_t            rd;
	alu_op_t           alu_op;
	logic [ALU_W-1:0]  alu_a;
	logic [ALU_W-1:0]  alu_b;
	logic [ALU_W:0]    alu_res;

	logic [REQ_W-1:0]  bytes;
	logic [NEED_W-1:0] need;
	logic              split;

	ffa_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (ram),
		.rd_data (rd)
	);

	ffa_alu u_alu (
		.op  (alu_op),
		.a   (alu_a),
		.b   (alu_b),
		.res (alu_res)
	);

	// granules needed, zero bytes counted as one
	assign bytes = (req_size == '0) ? REQ_W'(1) : req_size;
	assign need  = NEED_W'(bytes[REQ_W-1:GRAN_W]) + NEED_W'(|bytes[GRAN_W-1:0]);
	assign split = alu_res[ALU_W] && (alu_res[SZ_W-1:0] != '0);

	always_comb begin
		alu_op    = ALU_ADD;
		alu_a     = '0;
		alu_b     = '0;
		ram.we    = 1'b0;
		ram.waddr = g_q[IDX_W-1:0];
		ram.wdata = '0;
		ram.raddr = g_q[IDX_W-1:0];
		unique case (state_q)
			A_CMP: begin
				alu_op = ALU_SUB;
				alu_a  = ALU_W'(rd.size);
				alu_b  = ALU_W'(need_q);
			end
			A_NXT, C_NXT, T_NXT: begin
				alu_op = ALU_ADD_INC;
				alu_a  = ALU_W'(g_q);
				alu_b  = ALU_W'(sz_q);
			end
			A_REM: begin
				// remainder after the header of the split-off block
				alu_op = ALU_SUB_DEC;
				alu_a  = ALU_W'(diff_q);
			end
			A_RADR: begin
				alu_op    = ALU_ADD_INC;
				alu_a     = ALU_W'(g_q);
				alu_b     = ALU_W'(need_q);
				ram.we    = 1'b1;
				ram.waddr = alu_res[IDX_W-1:0];
				ram.wdata = '{free: 1'b1, size: rem_q};
			end
			A_WR: begin
				alu_op    = ALU_ADD_INC;
				alu_a     = ALU_W'(g_q);
				ram.we    = 1'b1;
				ram.wdata = '{free: 1'b0, size: split_q ? need_q[SZ_W-1:0] : sz_q};
			end
			D_EV: begin
				alu_op    = ALU_ADD_INC;
				alu_a     = ALU_W'(g_q);
				alu_b     = ALU_W'(rd.size);
				ram.we    = (g_q[IDX_W-1:0] == target_q) && !rd.free;
				ram.wdata = '{free: 1'b1, size: rd.size};
			end
			C_EV: begin
				alu_op = ALU_ADD_INC;
				alu_a  = ALU_W'(g_q);
				alu_b  = ALU_W'(rd.size);
			end
			C_NRD: begin
				ram.raddr = nb_q[IDX_W-1:0];
			end
			C_NEV: begin
				// absorb the next free block into the current one
				alu_op    = ALU_ADD_INC;
				alu_a     = ALU_W'(sz_q);
				alu_b     = ALU_W'(rd.size);
				ram.we    = rd.free;
				ram.wdata = '{free: 1'b1, size: alu_res[SZ_W-1:0]};
			end
			T_EV: begin
				alu_op = ALU_ADD;
				alu_a  = ALU_W'(tot_q);
				alu_b  = ALU_W'(rd.size);
			end
			T_MAX: begin
				alu_op = ALU_SUB_DEC;
				alu_a  = ALU_W'(sz_q);
				alu_b  = ALU_W'(best_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			g_q      <= '0;
			nb_q     <= '0;
			sz_q     <= '0;
			fr_q     <= 1'b0;
			diff_q   <= '0;
			rem_q    <= '0;
			split_q  <= 1'b0;
			need_q   <= '0;
			target_q <= '0;
			tot_q    <= '0;
			best_q   <= '0;
			status_q <= STAT_OK;
			offset_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						g_q      <= '0;
						tot_q    <= '0;
						best_q   <= '0;
						offset_q <= '0;
						need_q   <= need;
						target_q <= handle[HDL_W-1:GRAN_W] - IDX_W'(1);
						if (!req_type) begin
							state_q <= A_RD;
						end else if (handle == '0) begin
							status_q <= STAT_OK;
							state_q  <= T_RD;
						end else if (handle[GRAN_W-1:0] != '0) begin
							status_q <= STAT_BADH;
							state_q  <= T_RD;
						end else begin
							state_q <= D_RD;
						end
					end
				end
				A_RD: begin
					if (g_q[IDX_W]) begin
						status_q <= STAT_NOFIT;
						g_q      <= '0;
						state_q  <= T_RD;
					end else begin
						state_q <= A_CMP;
					end
				end
				A_CMP: begin
					sz_q   <= rd.size;
					diff_q <= alu_res[SZ_W-1:0];
					state_q <= (rd.free && alu_res[ALU_W]) ? A_REM : A_NXT;
				end
				A_NXT: begin
					g_q     <= alu_res[IDX_W:0];
					state_q <= A_RD;
				end
				A_REM: begin
					rem_q   <= alu_res[SZ_W-1:0];
					split_q <= split;
					state_q <= split ? A_RADR : A_WR;
				end
				A_RADR: begin
					state_q <= A_WR;
				end
				A_WR: begin
					offset_q <= {alu_res[IDX_W-1:0], {GRAN_W{1'b0}}};
					status_q <= STAT_OK;
					g_q      <= '0;
					state_q  <= T_RD;
				end
				D_RD: begin
					if (g_q > {1'b0, target_q}) begin
						status_q <= STAT_BADH;
						g_q      <= '0;
						state_q  <= T_RD;
					end else begin
						state_q <= D_EV;
					end
				end
				D_EV: begin
					if (g_q[IDX_W-1:0] == target_q) begin
						g_q <= '0;
						if (!rd.free) begin
							status_q <= STAT_OK;
							state_q  <= C_RD;
						end else begin
							// double free
							status_q <= STAT_BADH;
							state_q  <= T_RD;
						end
					end else begin
						g_q     <= alu_res[IDX_W:0];
						state_q <= D_RD;
					end
				end
				C_RD: begin
					if (g_q[IDX_W]) begin
						g_q     <= '0;
						state_q <= T_RD;
					end else begin
						state_q <= C_EV;
					end
				end
				C_EV: begin
					sz_q <= rd.size;
					if (rd.free && !alu_res[IDX_W]) begin
						nb_q    <= alu_res[IDX_W:0];
						state_q <= C_NRD;
					end else begin
						g_q     <= alu_res[IDX_W:0];
						state_q <= C_RD;
					end
				end
				C_NRD: begin
					state_q <= C_NEV;
				end
				C_NEV: begin
					if (rd.free) begin
						sz_q    <= alu_res[SZ_W-1:0];
						state_q <= C_NXT;
					end else begin
						g_q     <= nb_q;
						state_q <= C_RD;
					end
				end
				C_NXT: begin
					if (!alu_res[IDX_W]) begin
						nb_q    <= alu_res[IDX_W:0];
						state_q <= C_NRD;
					end else begin
						g_q     <= alu_res[IDX_W:0];
						state_q <= C_RD;
					end
				end
				T_RD: begin
					state_q <= g_q[IDX_W] ? S_DONE : T_EV;
				end
				T_EV: begin
					sz_q <= rd.size;
					fr_q <= rd.free;
					if (rd.free) begin
						tot_q <= alu_res[SZ_W-1:0];
					end
					state_q <= T_MAX;
				end
				T_MAX: begin
					if (fr_q && alu_res[ALU_W]) begin
						best_q <= sz_q;
					end
					state_q <= T_NXT;
				end
				T_NXT: begin
					g_q     <= alu_res[IDX_W:0];
					state_q <= T_RD;
				end
				S_DONE: begin
					if (take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign idle                = (state_q == S_IDLE);
	assign done                = (state_q == S_DONE);
	assign result.status       = status_q;
	assign result.offset       = offset_q;
	assign result.free_bytes   = {tot_q, {GRAN_W{1'b0}}};
	assign result.largest_free = {best_q, {GRAN_W{1'b0}}};

endmodule

`default_nettype wire

// ===== src/first_fit_heap_allocator.sv =====
// first-fit heap allocator: one request at a time, result held in an output register.
// an allocation walks the headers to the first free block that fits and splits it or
// takes it whole; a release walks the headers up to its target and, if that is in use,
// frees it and merges free neighbours; every request ends with a totals pass over all
// headers, at most 128; the single table read port and the one shared adder set the pace.
// a request is taken only when the last one is done, also while its result waits; reset:
// arst_n clears control at once, header 0 reads as one free 4080-byte block, no sweep.
`default_nettype none

module first_fit_heap_allocator (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic                      req_type,
	input  wire logic [ffa_pkg::REQ_W-1:0] req_size,
	input  wire logic [ffa_pkg::HDL_W-1:0] handle,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic [1:0]                     status,
	output logic [ffa_pkg::OFS_W-1:0]      offset,
	output logic [ffa_pkg::OFS_W-1:0]      free_bytes,
	output logic [ffa_pkg::OFS_W-1:0]      largest_free
);
	import ffa_pkg::*;

	logic    idle;
	logic    done;
	logic    take;
	logic    out_valid_q;
	result_t ctrl_res;
	result_t res_q;

	// result register is free when empty or being drained this cycle
	assign take = done && (!out_valid_q || out_ready);

	ffa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (in_valid && idle),
		.req_type (req_type),
		.req_size (req_size),
		.handle   (handle),
		.take     (take),
		.idle     (idle),
		.done     (done),
		.result   (ctrl_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q <= ctrl_res;
		end
	end

	assign in_ready     = idle;
	assign out_valid    = out_valid_q;
	assign status       = res_q.status;
	assign offset       = res_q.offset;
	assign free_bytes   = res_q.free_bytes;
	assign largest_free = res_q.largest_free;

endmodule

`default_nettype wire

// ===== src/ffa_checker.sv =====
// port-level checks for the allocator, attached to the top level by bind
// depends on ffa_pkg and first_fit_heap_allocator
`default_nettype none

module ffa_checker (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      in_valid,
	input wire logic                      in_ready,
	input wire logic                      req_type,
	input wire logic [ffa_pkg::REQ_W-1:0] req_size,
	input wire logic [ffa_pkg::HDL_W-1:0] handle,
	input wire logic                      out_valid,
	input wire logic                      out_ready,
	input wire logic [1:0]                status,
	input wire logic [ffa_pkg::OFS_W-1:0] offset,
	input wire logic [ffa_pkg::OFS_W-1:0] free_bytes,
	input wire logic [ffa_pkg::OFS_W-1:0] largest_free
);
	import ffa_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(offset)
			&& $stable(free_bytes) && $stable(largest_free))
		else $error("result changed while stalled");

	// one request at a time: busy right after a request is taken
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request taken while busy");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == STAT_OK || status == STAT_NOFIT || status == STAT_BADH))
		else $error("bad status code");

	a_fail_offset: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != STAT_OK |-> offset == '0)
		else $error("failed request granted an offset");

	a_largest: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> largest_free <= free_bytes
			&& largest_free[GRAN_W-1:0] == '0 && free_bytes[GRAN_W-1:0] == '0)
		else $error("free totals inconsistent");

endmodule

bind first_fit_heap_allocator ffa_checker u_ffa_checker (.*);

`default_nettype wire

// ===== bench/tb_first_fit_heap_allocator.sv =====
// testbench for first_fit_heap_allocator: queue-fed request driver, result monitor, watchdog
// keeps its own copy of the block table to predict every result; needs src/ffa_pkg.sv
`default_nettype none

module tb_first_fit_heap_allocator;

	import ffa_pkg::*;

	localparam logic REQ_ALLOC = 1'b0;
	localparam logic REQ_FREE  = 1'b1;

	localparam int HOLD_CYCLES  = 6000;
	localparam int STALL_LIMIT  = 40000;
	localparam int DRAIN_CYCLES = 3200;
	localparam int N_RANDOM     = 700;

	typedef struct {
		logic             typ;
		logic [REQ_W-1:0] size;
		logic [HDL_W-1:0] hdl;
	} heap_req_t;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             in_valid  = 1'b0;
	logic             in_ready;
	logic             req_type  = REQ_ALLOC;
	logic [REQ_W-1:0] req_size  = '0;
	logic [HDL_W-1:0] handle    = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic [1:0]       status;
	logic [OFS_W-1:0] offset;
	logic [OFS_W-1:0] free_bytes;
	logic [OFS_W-1:0] largest_free;

	first_fit_heap_allocator dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.req_type    (req_type),
		.req_size    (req_size),
		.handle      (handle),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.offset      (offset),
		.free_bytes  (free_bytes),
		.largest_free(largest_free)
	);

	// shadow block table: payload size in granules and free mark per header granule
	int unsigned gsize [NGRAN];
	bit          gfree [NGRAN];
	logic [OFS_W-1:0] live_handles [$];

	heap_req_t pending [$];
	result_t   expected_results [$];
	result_t   want_r;

	int  gen_count   = 0;
	int  taken_count = 0;
	int  mismatches  = 0;
	int  hold_left   = 0;
	int  stall_cycles = 0;
	bit  calm        = 1'b0;
	bit  hold_req    = 1'b0;
	bit  hold_done   = 1'b0;

	function automatic int unsigned next_hdr(int unsigned g);
		return g + 1 + gsize[g];
	endfunction

	function automatic void heap_reset();
		foreach (gsize[i]) begin
			gsize[i] = 0;
			gfree[i] = 1'b0;
		end
		gsize[0] = NGRAN - 1;
		gfree[0] = 1'b1;
		live_handles.delete();
	endfunction

	function automatic void merge_free();
		int unsigned g, n;
		g = 0;
		while (g < NGRAN) begin
			n = next_hdr(g);
			while (gfree[g] && n < NGRAN && gfree[n]) begin
				gsize[g] += 1 + gsize[n];
				n = next_hdr(g);
			end
			g = n;
		end
	endfunction

	function automatic result_t predict_request(logic typ, logic [REQ_W-1:0] sz,
			logic [HDL_W-1:0] hdl);
		result_t     r;
		int unsigned need, g, target, tot, best;
		int          idx;
		r.status = STAT_OK;
		r.offset = '0;
		if (typ == REQ_ALLOC) begin
			need = (sz == 0) ? 1 : (int'(sz) + GRANULE - 1) / GRANULE;
			r.status = STAT_NOFIT;
			g = 0;
			while (g < NGRAN) begin
				if (gfree[g] && gsize[g] >= need) begin
					// split only when the rest can hold a header and one granule
					if (gsize[g] >= need + 2) begin
						gsize[g + 1 + need] = gsize[g] - need - 1;
						gfree[g + 1 + need] = 1'b1;
						gsize[g] = need;
					end
					gfree[g] = 1'b0;
					r.offset = OFS_W'((g + 1) * GRANULE);
					r.status = STAT_OK;
					live_handles.push_back(r.offset);
					break;
				end
				g = next_hdr(g);
			end
		end else if (hdl != 0) begin
			r.status = STAT_BADH;
			if (hdl % GRANULE == 0) begin
				target = hdl / GRANULE - 1;
				g = 0;
				while (g < NGRAN && g <= target) begin
					if (g == target) begin
						if (!gfree[g]) begin
							gfree[g] = 1'b1;
							merge_free();
							r.status = STAT_OK;
							idx = -1;
							foreach (live_handles[i])
								if (live_handles[i] == hdl) idx = i;
							if (idx >= 0) live_handles.delete(idx);
						end
						break;
					end
					g = next_hdr(g);
				end
			end
		end
		tot = 0;
		best = 0;
		g = 0;
		while (g < NGRAN) begin
			if (gfree[g]) begin
				tot += gsize[g];
				if (gsize[g] > best) best = gsize[g];
			end
			g = next_hdr(g);
		end
		r.free_bytes   = OFS_W'(tot * GRANULE);
		r.largest_free = OFS_W'(best * GRANULE);
		return r;
	endfunction

	task automatic push_req(input logic typ, input logic [REQ_W-1:0] sz,
			input logic [HDL_W-1:0] hdl);
		heap_req_t r;
		while (pending.size() >= 4) @(negedge clk);
		r.typ  = typ;
		r.size = sz;
		r.hdl  = hdl;
		pending.push_back(r);
		gen_count++;
	endtask

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
	end

	// request driver
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				expected_results.push_back(predict_request(req_type, req_size, handle));
				taken_count++;
			end
			if (!in_valid || in_ready) begin
				if (pending.size() != 0 && (calm || $urandom_range(0, 99) >= 24)) begin
					req_type <= pending[0].typ;
					req_size <= pending[0].size;
					handle   <= pending[0].hdl;
					in_valid <= 1'b1;
					pending.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor, with one long hold-off so the block backs up
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result: status %0d offset %0d free %0d largest %0d",
							status, offset, free_bytes, largest_free);
				end else begin
					want_r = expected_results.pop_front();
					if (status !== want_r.status || offset !== want_r.offset ||
							free_bytes !== want_r.free_bytes ||
							largest_free !== want_r.largest_free) begin
						mismatches++;
						if (mismatches <= 10) begin
							$write("mismatch: exp status %0d offset %0d free %0d largest %0d",
								want_r.status, want_r.offset, want_r.free_bytes,
								want_r.largest_free);
							$display(" / got status %0d offset %0d free %0d largest %0d",
								status, offset, free_bytes, largest_free);
						end
					end
				end
			end
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else if (hold_req && !hold_done) begin
				hold_left <= HOLD_CYCLES;
				hold_done <= 1'b1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= calm || ($urandom_range(0, 99) >= 24);
			end
		end
	end

	// watchdog on cycles with no request or result moving
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin
		int               pick, sel;
		logic [REQ_W-1:0] size_r;
		logic [HDL_W-1:0] hdl_r;
		heap_reset();

		// directed: rounding, no fit, null and bad handles, double free, full heap, split edge
		push_req(REQ_ALLOC, 13'd0,    12'd0);
		push_req(REQ_ALLOC, 13'd4096, 12'd4095);
		push_req(REQ_ALLOC, 13'd4095, 12'd0);
		push_req(REQ_FREE,  13'd4096, 12'd0);
		push_req(REQ_FREE,  13'd0,    12'd4095);
		push_req(REQ_FREE,  13'd8,    12'd24);
		push_req(REQ_ALLOC, 13'd1,    12'd0);
		push_req(REQ_ALLOC, 13'd17,   12'd0);
		push_req(REQ_FREE,  13'd0,    12'd96);
		push_req(REQ_FREE,  13'd0,    12'd48);
		push_req(REQ_FREE,  13'd0,    12'd48);
		push_req(REQ_FREE,  13'd0,    12'd16);
		push_req(REQ_FREE,  13'd0,    12'd80);
		push_req(REQ_ALLOC, 13'd4080, 12'd0);
		push_req(REQ_ALLOC, 13'd16,   12'd0);
		push_req(REQ_FREE,  13'd0,    12'd16);
		// leftover of one granule stays inside the block
		push_req(REQ_ALLOC, 13'd4064, 12'd0);
		push_req(REQ_FREE,  13'd0,    12'd16);
		// leftover of two granules splits off a one-granule free block
		push_req(REQ_ALLOC, 13'd4048, 12'd0);
		push_req(REQ_ALLOC, 13'd0,    12'd0);
		push_req(REQ_FREE,  13'd0,    12'd16);
		push_req(REQ_ALLOC, 13'd4097, 12'd0);
		push_req(REQ_FREE,  13'd0,    12'd4080);

		for (int n = 0; n < N_RANDOM; n++) begin
			calm = (n >= 120 && n < 260);
			if (n == 420) hold_req = 1'b1;
			pick   = $urandom_range(0, 99);
			hdl_r  = HDL_W'($urandom_range(0, 4095));
			size_r = REQ_W'($urandom_range(0, 4096));
			if (live_handles.size() == 0 || (pick < 50 && live_handles.size() < 40)) begin
				// mostly small requests so the header walk stays short
				sel = $urandom_range(0, 99);
				if (sel < 70)
					size_r = REQ_W'($urandom_range(0, 64));
				else if (sel < 90)
					size_r = REQ_W'($urandom_range(65, 512));
				else if (sel < 98)
					size_r = REQ_W'($urandom_range(513, 2048));
				else
					size_r = REQ_W'($urandom_range(2049, 4096));
				push_req(REQ_ALLOC, size_r, hdl_r);
			end else if (pick < 92) begin
				push_req(REQ_FREE, size_r,
					live_handles[$urandom_range(0, live_handles.size() - 1)]);
			end else if (pick < 96) begin
				// aligned junk: mid-block, free block or past the end
				push_req(REQ_FREE, size_r, hdl_r & 12'hff0);
			end else begin
				push_req(REQ_FREE, size_r, hdl_r);
			end
		end
		calm = 1'b0;

		while (taken_count != gen_count) @(negedge clk);
		while (expected_results.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

`default_nettype wire
